// ----- src/direct_mapped_cache_tag_check_unit_defines.svh -----
// Assertion macros for the tag check unit.
`ifndef DIRECT_MAPPED_CACHE_TAG_CHECK_UNIT_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_TAG_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DMCTC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tag check unit: same-cycle check failed");

// Next-cycle implication.
`define DMCTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tag check unit: next-cycle check failed");

`else

`define DMCTC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define DMCTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- src/dmctc_pkg.sv -----
package dmctc_pkg;

  localparam int unsigned ADDR_W = 64;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CHECK = 3'b100
  } state_e;

  typedef struct packed {
    logic clear;   // write an invalid entry at the sweep address
    logic accept;  // latch request, read tag RAM
    logic check;   // compare, write back, update counts, strobe result
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } ctrl_sts_t;

endpackage

// ----- src/dmctc_ctrl.sv -----
module dmctc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  dmctc_pkg::ctrl_sts_t sts_i,
  output dmctc_pkg::ctrl_cmd_t cmd_o
);

  dmctc_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      dmctc_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = dmctc_pkg::ST_IDLE;
        end
      end
      dmctc_pkg::ST_IDLE: begin
        if (start) begin
          state_d = dmctc_pkg::ST_CHECK;
        end
      end
      dmctc_pkg::ST_CHECK: begin
        state_d = dmctc_pkg::ST_IDLE;
      end
      default: begin
        state_d = dmctc_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmctc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy         = (state_q != dmctc_pkg::ST_IDLE);
  assign cmd_o.clear  = (state_q == dmctc_pkg::ST_CLEAR);
  assign cmd_o.accept = (state_q == dmctc_pkg::ST_IDLE) && start;
  assign cmd_o.check  = (state_q == dmctc_pkg::ST_CHECK);

endmodule

// ----- src/dmctc_dpath.sv -----
module dmctc_dpath #(
  parameter int unsigned LINE_OFFSET_BITS = 3,
  parameter int unsigned CACHE_SIZE_LOG2  = 17,
  parameter int unsigned COUNT_WIDTH      = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dmctc_pkg::ctrl_cmd_t                    cmd_i,
  output dmctc_pkg::ctrl_sts_t                    sts_o,
  input  logic                                    kind_i,
  input  logic [dmctc_pkg::ADDR_W-1:0]            address_i,
  output logic                                    done_o,
  output logic                                    hit_o,
  output logic [CACHE_SIZE_LOG2-LINE_OFFSET_BITS-1:0] line_index_o,
  output logic [COUNT_WIDTH-1:0]                  hit_count_o,
  output logic [COUNT_WIDTH-1:0]                  access_count_o
);

  localparam int unsigned IDX_W     = CACHE_SIZE_LOG2 - LINE_OFFSET_BITS;
  localparam int unsigned NUM_LINES = 1 << IDX_W;
  localparam int unsigned TAG_W     = dmctc_pkg::ADDR_W - CACHE_SIZE_LOG2;
  localparam int unsigned ENTRY_W   = TAG_W + 2;

  // entry layout: {valid, dirty, tag}
  logic [ENTRY_W-1:0] mem_q [NUM_LINES];
  logic [ENTRY_W-1:0] rd_q;
  logic [ENTRY_W-1:0] wdata;
  logic [IDX_W-1:0]   waddr;
  logic               we;

  logic [IDX_W-1:0]   clr_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TAG_W-1:0]   tag_q;
  logic               kind_q;
  logic               hit;
  logic               dirty_new;
  logic               hit_q;
  logic               done_q;
  logic [COUNT_WIDTH-1:0] hits_q;
  logic [COUNT_WIDTH-1:0] accs_q;

  assign hit       = rd_q[ENTRY_W-1] && (rd_q[TAG_W-1:0] == tag_q);
  assign dirty_new = (hit && rd_q[TAG_W]) || (kind_q == dmctc_pkg::KIND_WRITE);

  always_comb begin
    we    = cmd_i.clear || cmd_i.check;
    waddr = cmd_i.clear ? clr_q : idx_q;
    wdata = cmd_i.clear ? '0 : {1'b1, dirty_new, tag_q};
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.accept) begin
      rd_q <= mem_q[address_i[CACHE_SIZE_LOG2-1:LINE_OFFSET_BITS]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q  <= address_i[CACHE_SIZE_LOG2-1:LINE_OFFSET_BITS];
      tag_q  <= address_i[dmctc_pkg::ADDR_W-1:CACHE_SIZE_LOG2];
      kind_q <= kind_i;
    end
    if (cmd_i.check) begin
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      done_q <= 1'b0;
      hits_q <= '0;
      accs_q <= '0;
    end else begin
      done_q <= cmd_i.check;
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.check) begin
        if (accs_q != '1) begin
          accs_q <= accs_q + 1'b1;
        end
        if (hit && (hits_q != '1)) begin
          hits_q <= hits_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.clr_last = (clr_q == '1);

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign line_index_o   = idx_q;
  assign hit_count_o    = hits_q;
  assign access_count_o = accs_q;

endmodule

// ----- src/direct_mapped_cache_tag_check_unit.sv -----
// Channel   Handshake           Payload
// request   start / busy        kind_i, address_i
// result    done_o (strobe)     hit_o, line_index_o, hit_count_o, access_count_o
//
// A request reads the tag RAM at the accept edge (registered read port), then
// is compared and written back in the following cycle.
// The result strobe comes the cycle after; busy is already low then, so the
// next request can be accepted in that cycle, but not while one is in check.
// After reset a clearing pass writes all 2^(CACHE_SIZE_LOG2 - LINE_OFFSET_BITS)
// lines invalid, with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
`include "direct_mapped_cache_tag_check_unit_defines.svh"

module direct_mapped_cache_tag_check_unit #(
  parameter int unsigned LINE_OFFSET_BITS = 3,
  parameter int unsigned CACHE_SIZE_LOG2  = 17,
  parameter int unsigned COUNT_WIDTH      = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start,
  output logic                                        busy,
  input  logic                                        kind_i,
  input  logic [dmctc_pkg::ADDR_W-1:0]                address_i,
  output logic                                        done_o,
  output logic                                        hit_o,
  output logic [CACHE_SIZE_LOG2-LINE_OFFSET_BITS-1:0] line_index_o,
  output logic [COUNT_WIDTH-1:0]                      hit_count_o,
  output logic [COUNT_WIDTH-1:0]                      access_count_o
);

  dmctc_pkg::ctrl_cmd_t cmd;
  dmctc_pkg::ctrl_sts_t sts;
  logic                 accept;

  assign accept = start && !busy;

  dmctc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  dmctc_dpath #(
    .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
    .CACHE_SIZE_LOG2  (CACHE_SIZE_LOG2),
    .COUNT_WIDTH      (COUNT_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .address_i      (address_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .line_index_o   (line_index_o),
    .hit_count_o    (hit_count_o),
    .access_count_o (access_count_o)
  );

  `DMCTC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy && !done_o)
  `DMCTC_ASSERT_NEXT(a_accept_done, clk_i, rst_ni, accept, ##1 done_o)
  `DMCTC_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy && (access_count_o != '0))
  `DMCTC_ASSERT_SAME(a_hit_le_acc, clk_i, rst_ni, done_o, hit_count_o <= access_count_o)

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ADDR_W = dmctc_pkg::ADDR_W;
  localparam int unsigned OFFSET_W = 3;
  localparam int unsigned SIZE_LOG2 = 17;
  localparam int unsigned INDEX_W = SIZE_LOG2 - OFFSET_W;
  localparam int unsigned TAG_W = ADDR_W - SIZE_LOG2;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned LINES = 1 << INDEX_W;
  localparam int unsigned RANDOM_REQS = 700;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] line;
    logic [CNT_W-1:0]   hits;
    logic [CNT_W-1:0]   accesses;
  } lookup_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                kind_i = dmctc_pkg::KIND_READ;
  logic [ADDR_W-1:0]   address_i = '0;
  logic                done_o;
  logic                hit_o;
  logic [INDEX_W-1:0]  line_index_o;
  logic [CNT_W-1:0]    hit_count_o;
  logic [CNT_W-1:0]    access_count_o;

  // Mirror of the tag store.
  logic [TAG_W-1:0]    tag_mem [LINES];
  bit                  valid_mem [LINES];
  bit                  dirty_mem [LINES];
  logic [CNT_W-1:0]    hits_total = '0;
  logic [CNT_W-1:0]    accesses_total = '0;

  request_t            request_q [$];
  lookup_t             pending_lookups [$];
  int                  idle_left = 0;
  int                  n_issued = 0;
  int                  n_results = 0;
  int                  n_writes = 0;
  int                  n_evict_dirty = 0;
  int                  fail_count = 0;

  always #2 clk_i = ~clk_i;

  direct_mapped_cache_tag_check_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .address_i      (address_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .line_index_o   (line_index_o),
    .hit_count_o    (hit_count_o),
    .access_count_o (access_count_o)
  );

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic lookup_t lookup_line(logic kind, logic [ADDR_W-1:0] addr);
    lookup_t            r;
    logic [INDEX_W-1:0] idx;
    logic [TAG_W-1:0]   tag;
    idx = addr[SIZE_LOG2-1:OFFSET_W];
    tag = addr[ADDR_W-1:SIZE_LOG2];
    r.hit = valid_mem[idx] && (tag_mem[idx] == tag);
    if (kind == dmctc_pkg::KIND_WRITE) n_writes++;
    if (r.hit) begin
      if (kind == dmctc_pkg::KIND_WRITE) dirty_mem[idx] = 1'b1;
      hits_total = sat_inc(hits_total);
    end else begin
      if (valid_mem[idx] && dirty_mem[idx]) n_evict_dirty++;
      tag_mem[idx] = tag;
      valid_mem[idx] = 1'b1;
      dirty_mem[idx] = (kind == dmctc_pkg::KIND_WRITE);
    end
    accesses_total = sat_inc(accesses_total);
    r.line = idx;
    r.hits = hits_total;
    r.accesses = accesses_total;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %0h, got %0h (result %0d)", name, want, got, n_results);
    end
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    request_t req;
    bit       idle_ok;
    if (!rst_ni) begin
      start <= 1'b0;
      kind_i <= dmctc_pkg::KIND_READ;
      address_i <= '0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        pending_lookups.insert(pending_lookups.size(), lookup_line(kind_i, address_i));
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          start <= 1'b0;
          idle_left--;
        end else if (request_q.size() > 0) begin
          req = request_q.pop_front();
          start <= 1'b1;
          kind_i <= req.kind;
          address_i <= req.addr;
          n_issued++;
          idle_ok = (request_q.size() > 120) && (((n_issued / 64) % 2) == 0);
          if (idle_ok && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 18);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_lookups.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with no request outstanding");
      end else begin
        want = pending_lookups.pop_front();
        check_field("hit", 64'(want.hit), 64'(hit_o));
        check_field("line_index", 64'(want.line), 64'(line_index_o));
        check_field("hit_count", 64'(want.hits), 64'(hit_count_o));
        check_field("access_count", 64'(want.accesses), 64'(access_count_o));
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] hot_addr [24];
    logic [TAG_W-1:0]  tag_pool [6];
    request_t          req;
    int                pick;
    int                slot;
    int                n;

    foreach (tag_mem[i]) tag_mem[i] = '0;

    // directed: cold miss, same-line hit, write hit, extremes, conflicts
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'h0});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'h7});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_WRITE, 64'h0});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFF});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'hFFFF_FFFF_FFFF_FFF8});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'h2_0000});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_WRITE, 64'h0});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'h8});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_WRITE, 64'hF});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'hFFFF_FFFF_FFFE_0000});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'h1_FFF8});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFF8});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'hFFFF_FFFF_FFFF_FFFF});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_WRITE, 64'hAAAA_AAAA_AAAA_AAAA});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'h5555_5555_5555_5555});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'hAAAA_AAAA_AAAA_AAAF});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_WRITE, 64'h5555_5555_5555_5550});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'h8000_0000_0000_0000});
    request_q.insert(request_q.size(), '{dmctc_pkg::KIND_READ,  64'h8000_0000_0000_0007});

    // random: mostly a small working set so hits, dirty evictions and
    // same-line back-to-back requests are common
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'({$urandom, $urandom});
    foreach (hot_addr[i])
      hot_addr[i] = {tag_pool[$urandom_range(0, 5)], 3'b000, 11'($urandom), 3'b000};
    for (n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, 23);
      req.kind = $urandom_range(0, 1) ? dmctc_pkg::KIND_WRITE : dmctc_pkg::KIND_READ;
      if (pick < 45) begin
        req.addr = hot_addr[slot];
        req.addr[OFFSET_W-1:0] = OFFSET_W'($urandom);
      end else if (pick < 75) begin
        req.addr = hot_addr[slot];
        req.addr[ADDR_W-1:SIZE_LOG2] = tag_pool[$urandom_range(0, 5)];
        req.addr[OFFSET_W-1:0] = OFFSET_W'($urandom);
        if ($urandom_range(0, 1)) hot_addr[slot] = req.addr;
      end else begin
        req.addr = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) hot_addr[slot] = req.addr;
      end
      request_q.insert(request_q.size(), req);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() > 0 || start || pending_lookups.size() > 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (pending_lookups.size() > 0) begin
      fail_count += pending_lookups.size();
      $display("%0d results never arrived", pending_lookups.size());
    end
    $display("%0d requests (%0d writes), %0d results, %0d hits, %0d dirty lines replaced",
             n_issued, n_writes, n_results, hits_total, n_evict_dirty);
    $display("%0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- direct_mapped_cache_tag_check_unit.f -----
+incdir+src
src/dmctc_pkg.sv
src/dmctc_ctrl.sv
src/dmctc_dpath.sv
src/direct_mapped_cache_tag_check_unit.sv
verif/tb_top.sv
